// ----- hw/rtl/lobm_pkg.sv -----
`timescale 1ns / 1ps

package lobm_pkg;

   // book geometry
   localparam int SIDE_DEPTH = 8;
   localparam int NSLOT      = 2 * SIDE_DEPTH;
   localparam int SLOT_W     = $clog2(NSLOT);
   localparam int CNT_W      = $clog2(SIDE_DEPTH + 1);

   // field widths
   localparam int MODE_W = 3;
   localparam int KIND_W = 4;
   localparam int ID_W   = 32;
   localparam int PX_W   = 32;
   localparam int QTY_W  = 24;
   localparam int AVG_W  = 48;
   localparam int FRAC_W = 16;

   // average update: numerator q*P*2^16 + avg*cum, denominator q + cum
   localparam int PROD_W = QTY_W + PX_W;
   localparam int NUM_W  = 73;
   localparam int DEN_W  = QTY_W + 1;
   localparam int STEP_W = $clog2(NUM_W);

   // item modes
   localparam logic [MODE_W-1:0] MODE_NEW     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CANCEL  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STATUS  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MATCH   = 3'd4;

   // report kinds
   localparam logic [KIND_W-1:0] KIND_NEW        = 4'd0;
   localparam logic [KIND_W-1:0] KIND_CANCELED   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_PEND_REPL  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_REPLACED   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_PARTIAL    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_FILLED     = 4'd5;
   localparam logic [KIND_W-1:0] KIND_STATUS     = 4'd6;
   localparam logic [KIND_W-1:0] KIND_CXL_REJ    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_REPL_REJ   = 4'd8;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 4'd9;
   localparam logic [KIND_W-1:0] KIND_BOOK_FULL  = 4'd10;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PX_W-1:0]  price;
      logic [QTY_W-1:0] order_qty;
      logic [QTY_W-1:0] leaves_qty;
      logic [QTY_W-1:0] cum_qty;
      logic [QTY_W-1:0] last_qty;
      logic [AVG_W-1:0] avg_price;
      logic [PX_W-1:0]  last_price;
   } entry_type;

   typedef struct packed {
      logic [KIND_W-1:0] report_kind;
      logic [ID_W-1:0]   report_order_id;
      logic [ID_W-1:0]   report_orig_id;
      logic              report_side;
      logic [QTY_W-1:0]  order_qty;
      logic [QTY_W-1:0]  leaves_qty;
      logic [QTY_W-1:0]  cum_qty;
      logic [AVG_W-1:0]  avg_price;
      logic [QTY_W-1:0]  last_qty;
      logic [PX_W-1:0]   last_price;
      logic [ID_W-1:0]   exec_id;
      logic              last_in_run;
   } report_type;

   typedef struct packed {
      logic [AVG_W-1:0] avg;
      logic [QTY_W-1:0] cum;
      logic [PX_W-1:0]  px;
      logic [QTY_W-1:0] q;
   } avg_op_type;

   // engine to output queue
   typedef struct packed {
      logic       emit;
      logic       finish;
      report_type rep;
   } oq_cmd_type;

   // output queue to engine
   typedef struct packed {
      logic pend_valid;
      logic out_free;
   } oq_stat_type;

   // table slot of entry idx on a side (bids first, then asks)
   function automatic logic [SLOT_W-1:0] slot(input logic side, input logic [CNT_W-1:0] idx);
      slot = SLOT_W'(side ? SIDE_DEPTH : 0) + SLOT_W'(idx);
   endfunction

endpackage

// ----- hw/rtl/lobm_ifs.sv -----
`timescale 1ns / 1ps

interface lobm_req_if;
   logic                            valid;
   logic                            ready;
   logic [lobm_pkg::MODE_W-1:0]     mode;
   logic [lobm_pkg::ID_W-1:0]       order_id;
   logic [lobm_pkg::ID_W-1:0]       orig_order_id;
   logic                            side;
   logic [lobm_pkg::PX_W-1:0]       price;
   logic [lobm_pkg::QTY_W-1:0]      quantity;

   modport source (output valid, mode, order_id, orig_order_id, side, price, quantity,
                   input ready);
   modport sink (input valid, mode, order_id, orig_order_id, side, price, quantity,
                 output ready);
endinterface

interface lobm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lobm_pkg::KIND_W-1:0]     report_kind;
   logic [lobm_pkg::ID_W-1:0]       report_order_id;
   logic [lobm_pkg::ID_W-1:0]       report_orig_id;
   logic                            report_side;
   logic [lobm_pkg::QTY_W-1:0]      order_qty;
   logic [lobm_pkg::QTY_W-1:0]      leaves_qty;
   logic [lobm_pkg::QTY_W-1:0]      cum_qty;
   logic [lobm_pkg::AVG_W-1:0]      avg_price;
   logic [lobm_pkg::QTY_W-1:0]      last_qty;
   logic [lobm_pkg::PX_W-1:0]       last_price;
   logic [lobm_pkg::ID_W-1:0]       exec_id;
   logic                            last_in_run;

   modport source (output valid, report_kind, report_order_id, report_orig_id, report_side,
                   order_qty, leaves_qty, cum_qty, avg_price, last_qty, last_price,
                   exec_id, last_in_run,
                   input ready);
   modport sink (input valid, report_kind, report_order_id, report_orig_id, report_side,
                 order_qty, leaves_qty, cum_qty, avg_price, last_qty, last_price,
                 exec_id, last_in_run,
                 output ready);
endinterface

// ----- hw/rtl/lobm_avg_unit.sv -----
`timescale 1ns / 1ps

// Average price update: three 24x32 partial products accumulated into the
// numerator, then restoring division by cum + q, one quotient bit a cycle.
module lobm_avg_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  lobm_pkg::avg_op_type          op,
   output logic                          done,
   output logic [lobm_pkg::AVG_W-1:0]    result
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]                      phase_ff, phase_in;
   logic [lobm_pkg::STEP_W-1:0]     step_ff, step_in;
   lobm_pkg::avg_op_type            op_ff, op_in;
   logic [lobm_pkg::DEN_W-1:0]      den_ff, den_in;
   logic [lobm_pkg::DEN_W-1:0]      rem_ff, rem_in;
   logic [lobm_pkg::NUM_W-1:0]      acc_ff, acc_in;
   logic [lobm_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic                            done_ff, done_in;

   logic [lobm_pkg::QTY_W-1:0]      mul_a;
   logic [lobm_pkg::PX_W-1:0]       mul_b;
   logic [lobm_pkg::NUM_W-1:0]      addend;
   logic [lobm_pkg::DEN_W:0]        trial;
   logic [lobm_pkg::DEN_W:0]        diff;
   logic                            ge;

   // multiplier operand select per step
   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            mul_a = op_ff.q;
            mul_b = op_ff.px;
         end
         2'd1: begin
            mul_a = op_ff.cum;
            mul_b = lobm_pkg::PX_W'(op_ff.avg[lobm_pkg::QTY_W-1:0]);
         end
         default: begin
            mul_a = op_ff.cum;
            mul_b = lobm_pkg::PX_W'(op_ff.avg[lobm_pkg::AVG_W-1:lobm_pkg::QTY_W]);
         end
      endcase
   end

   // weight of the registered product
   always_comb begin
      case (step_ff[1:0])
         2'd1:    addend = lobm_pkg::NUM_W'(prod_ff) << lobm_pkg::FRAC_W;
         2'd2:    addend = lobm_pkg::NUM_W'(prod_ff);
         2'd3:    addend = lobm_pkg::NUM_W'(prod_ff) << lobm_pkg::QTY_W;
         default: addend = '0;
      endcase
   end

   // one restoring division step
   assign trial = {rem_ff, acc_ff[lobm_pkg::NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      op_in    = op_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               op_in    = op;
               den_in   = lobm_pkg::DEN_W'(op.cum) + lobm_pkg::DEN_W'(op.q);
               acc_in   = '0;
               step_in  = '0;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            prod_in = mul_a * mul_b;
            acc_in  = acc_ff + addend;
            if (step_ff == lobm_pkg::STEP_W'(3)) begin
               phase_in = PH_DIV;
               step_in  = '0;
               rem_in   = '0;
            end else begin
               step_in = step_ff + lobm_pkg::STEP_W'(1);
            end
         end
         PH_DIV: begin
            rem_in = ge ? diff[lobm_pkg::DEN_W-1:0] : trial[lobm_pkg::DEN_W-1:0];
            acc_in = {acc_ff[lobm_pkg::NUM_W-2:0], ge};
            if (step_ff == lobm_pkg::STEP_W'(lobm_pkg::NUM_W - 1)) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else begin
               step_in = step_ff + lobm_pkg::STEP_W'(1);
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      op_ff   <= op_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[lobm_pkg::AVG_W-1:0];

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> phase_ff == PH_IDLE)
      else $error("avg unit started while busy");
   a_done_after_div: assert property (@(posedge clock) disable iff (reset)
      done_in |-> phase_ff == PH_DIV)
      else $error("avg done outside division");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIV && step_ff != '0) |-> rem_ff < den_ff)
      else $error("remainder not below divisor");
`endif

endmodule

// ----- hw/rtl/lobm_out_queue.sv -----
`timescale 1ns / 1ps

// Holds the newest report until it is known whether another follows, then
// passes it to the output register with last_in_run set accordingly.
module lobm_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  lobm_pkg::oq_cmd_type  cmd,
   output lobm_pkg::oq_stat_type stat,
   lobm_rsp_if.source            rsp
);

   logic                    pend_valid_ff, pend_valid_in;
   lobm_pkg::report_type    pend_ff, pend_in;
   logic                    out_valid_ff, out_valid_in;
   lobm_pkg::report_type    out_ff, out_in;
   logic                    out_free;

   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         // a new report shows the held one was not the last
         if (pend_valid_ff) begin
            out_in             = pend_ff;
            out_in.last_in_run = 1'b0;
            out_valid_in       = 1'b1;
         end
         pend_in       = cmd.rep;
         pend_valid_in = 1'b1;
      end else if (cmd.finish && pend_valid_ff) begin
         out_in             = pend_ff;
         out_in.last_in_run = 1'b1;
         out_valid_in       = 1'b1;
         pend_valid_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   assign rsp.valid           = out_valid_ff;
   assign rsp.report_kind     = out_ff.report_kind;
   assign rsp.report_order_id = out_ff.report_order_id;
   assign rsp.report_orig_id  = out_ff.report_orig_id;
   assign rsp.report_side     = out_ff.report_side;
   assign rsp.order_qty       = out_ff.order_qty;
   assign rsp.leaves_qty      = out_ff.leaves_qty;
   assign rsp.cum_qty         = out_ff.cum_qty;
   assign rsp.avg_price       = out_ff.avg_price;
   assign rsp.last_qty        = out_ff.last_qty;
   assign rsp.last_price      = out_ff.last_price;
   assign rsp.exec_id         = out_ff.exec_id;
   assign rsp.last_in_run     = out_ff.last_in_run;

`ifndef SYNTHESIS
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && pend_valid_ff) |-> out_free)
      else $error("report pushed over a full output word");
   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && pend_valid_ff) |-> out_free)
      else $error("run closed over a full output word");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && cmd.finish))
      else $error("emit and finish together");
`endif

endmodule

// ----- hw/rtl/lobm_engine.sv -----
`timescale 1ns / 1ps

// Order book sequencer. Both sides live in one entry memory (bids in the
// low half, asks in the high half); every shifting walk is a read followed
// by a write in the cycle after it, never to the slot being read in the same cycle.
module lobm_engine (
   input  logic                  clock,
   input  logic                  reset,
   lobm_req_if.sink              req,
   input  logic                  auto_match,
   input  lobm_pkg::oq_stat_type oq_stat,
   output lobm_pkg::oq_cmd_type  oq_cmd
);

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_DISP     = 5'd1;
   localparam logic [4:0] ST_FIND_RD  = 5'd2;
   localparam logic [4:0] ST_FIND_CMP = 5'd3;
   localparam logic [4:0] ST_RM_RD    = 5'd4;
   localparam logic [4:0] ST_RM_WR    = 5'd5;
   localparam logic [4:0] ST_REPL     = 5'd6;
   localparam logic [4:0] ST_ADD      = 5'd7;
   localparam logic [4:0] ST_INS_RD   = 5'd8;
   localparam logic [4:0] ST_INS_CHK  = 5'd9;
   localparam logic [4:0] ST_INS_PUT  = 5'd10;
   localparam logic [4:0] ST_MT_TOP   = 5'd11;
   localparam logic [4:0] ST_MT_RDA   = 5'd12;
   localparam logic [4:0] ST_MT_CHK   = 5'd13;
   localparam logic [4:0] ST_AVG_A    = 5'd14;
   localparam logic [4:0] ST_AVG_B    = 5'd15;
   localparam logic [4:0] ST_MT_WRA   = 5'd16;
   localparam logic [4:0] ST_MT_WRB   = 5'd17;
   localparam logic [4:0] ST_MT_POST  = 5'd18;
   localparam logic [4:0] ST_EMIT     = 5'd19;
   localparam logic [4:0] ST_FINISH   = 5'd20;

   // entry memory
   lobm_pkg::entry_type             mem_ff [lobm_pkg::NSLOT];
   lobm_pkg::entry_type             rd_data_ff;
   logic                            mem_we, mem_re;
   logic [lobm_pkg::SLOT_W-1:0]     mem_waddr, mem_raddr;
   lobm_pkg::entry_type             mem_wdata;

   // control and item registers
   logic [4:0]                      state_ff, state_in;
   logic [4:0]                      ret_ff, ret_in;
   logic [4:0]                      rm_ret_ff, rm_ret_in;
   logic [lobm_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic [lobm_pkg::ID_W-1:0]       oid_ff, oid_in;
   logic [lobm_pkg::ID_W-1:0]       orig_ff, orig_in;
   logic                            side_ff, side_in;
   logic [lobm_pkg::PX_W-1:0]       px_ff, px_in;
   logic [lobm_pkg::QTY_W-1:0]      qty_ff, qty_in;
   logic [lobm_pkg::CNT_W-1:0]      bid_cnt_ff, bid_cnt_in;
   logic [lobm_pkg::CNT_W-1:0]      ask_cnt_ff, ask_cnt_in;
   logic [lobm_pkg::ID_W-1:0]       exec_ff, exec_in;
   logic [lobm_pkg::CNT_W-1:0]      j_ff, j_in;
   logic                            rm_side_ff, rm_side_in;
   logic                            rm_a_ff, rm_a_in;
   logic                            rm_b_ff, rm_b_in;
   logic [lobm_pkg::QTY_W-1:0]      q_ff, q_in;
   lobm_pkg::entry_type             ent_a_ff, ent_a_in;
   lobm_pkg::entry_type             ent_b_ff, ent_b_in;
   lobm_pkg::report_type            rep_ff, rep_in;

   // average unit
   logic                            avg_start, avg_done;
   lobm_pkg::avg_op_type            avg_op;
   logic [lobm_pkg::AVG_W-1:0]      avg_res;

   // helpers
   logic                            oq_ok;
   logic [lobm_pkg::CNT_W-1:0]      cnt_s, rm_cnt, j_inc, j_dec;
   logic [lobm_pkg::ID_W-1:0]       key;
   logic                            move;
   logic [lobm_pkg::QTY_W-1:0]      q_min;

   function automatic lobm_pkg::report_type rep_plain(
      input logic [lobm_pkg::KIND_W-1:0] kind,
      input logic [lobm_pkg::ID_W-1:0]   id,
      input logic [lobm_pkg::ID_W-1:0]   orig,
      input logic                        side,
      input logic [lobm_pkg::QTY_W-1:0]  qty,
      input logic [lobm_pkg::ID_W-1:0]   ex);
      lobm_pkg::report_type r;
      r                 = '0;
      r.report_kind     = kind;
      r.report_order_id = id;
      r.report_orig_id  = orig;
      r.report_side     = side;
      r.order_qty       = qty;
      r.leaves_qty      = qty;
      r.exec_id         = ex;
      return r;
   endfunction

   function automatic lobm_pkg::report_type rep_entry(
      input logic [lobm_pkg::KIND_W-1:0] kind,
      input lobm_pkg::entry_type         e,
      input logic [lobm_pkg::ID_W-1:0]   id,
      input logic [lobm_pkg::ID_W-1:0]   orig,
      input logic                        side,
      input logic [lobm_pkg::ID_W-1:0]   ex);
      lobm_pkg::report_type r;
      r.report_kind     = kind;
      r.report_order_id = id;
      r.report_orig_id  = orig;
      r.report_side     = side;
      r.order_qty       = e.order_qty;
      r.leaves_qty      = e.leaves_qty;
      r.cum_qty         = e.cum_qty;
      r.avg_price       = e.avg_price;
      r.last_qty        = e.last_qty;
      r.last_price      = e.last_price;
      r.exec_id         = ex;
      r.last_in_run     = 1'b0;
      return r;
   endfunction

   lobm_avg_unit u_avg (
      .clock  (clock),
      .reset  (reset),
      .start  (avg_start),
      .op     (avg_op),
      .done   (avg_done),
      .result (avg_res)
   );

   assign oq_ok  = !oq_stat.pend_valid || oq_stat.out_free;
   assign cnt_s  = side_ff ? ask_cnt_ff : bid_cnt_ff;
   assign rm_cnt = rm_side_ff ? ask_cnt_ff : bid_cnt_ff;
   assign j_inc  = j_ff + lobm_pkg::CNT_W'(1);
   assign j_dec  = j_ff - lobm_pkg::CNT_W'(1);
   assign key    = (mode_ff == lobm_pkg::MODE_STATUS) ? oid_ff : orig_ff;
   assign move   = side_ff ? (rd_data_ff.price > px_ff) : (rd_data_ff.price < px_ff);
   assign q_min  = (ent_b_ff.leaves_qty > rd_data_ff.leaves_qty) ?
                   rd_data_ff.leaves_qty : ent_b_ff.leaves_qty;
   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      rm_ret_in  = rm_ret_ff;
      mode_in    = mode_ff;
      oid_in     = oid_ff;
      orig_in    = orig_ff;
      side_in    = side_ff;
      px_in      = px_ff;
      qty_in     = qty_ff;
      bid_cnt_in = bid_cnt_ff;
      ask_cnt_in = ask_cnt_ff;
      exec_in    = exec_ff;
      j_in       = j_ff;
      rm_side_in = rm_side_ff;
      rm_a_in    = rm_a_ff;
      rm_b_in    = rm_b_ff;
      q_in       = q_ff;
      ent_a_in   = ent_a_ff;
      ent_b_in   = ent_b_ff;
      rep_in     = rep_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = '0;
      mem_raddr  = '0;
      mem_wdata  = rd_data_ff;
      avg_start  = 1'b0;
      avg_op     = '{avg: ent_b_ff.avg_price, cum: ent_b_ff.cum_qty,
                     px: ent_a_ff.price, q: q_ff};
      oq_cmd     = '0;
      oq_cmd.rep = rep_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               mode_in  = req.mode;
               oid_in   = req.order_id;
               orig_in  = req.orig_order_id;
               side_in  = req.side;
               px_in    = req.price;
               qty_in   = req.quantity;
               state_in = ST_DISP;
            end
         end

         ST_DISP: begin
            j_in = '0;
            unique case (mode_ff) inside
               lobm_pkg::MODE_NEW: begin
                  state_in = ST_EMIT;
                  if (cnt_s >= lobm_pkg::CNT_W'(lobm_pkg::SIDE_DEPTH)) begin
                     rep_in = rep_plain(lobm_pkg::KIND_BOOK_FULL, oid_ff, '0, side_ff, '0, '0);
                     ret_in = ST_FINISH;
                  end else begin
                     rep_in  = rep_plain(lobm_pkg::KIND_NEW, oid_ff, '0, side_ff, qty_ff,
                                         exec_ff);
                     exec_in = exec_ff + 32'd1;
                     ret_in  = ST_ADD;
                  end
               end
               lobm_pkg::MODE_CANCEL,
               lobm_pkg::MODE_REPLACE,
               lobm_pkg::MODE_STATUS: state_in = ST_FIND_RD;
               lobm_pkg::MODE_MATCH:  state_in = ST_MT_TOP;
               default:               state_in = ST_FINISH;
            endcase
         end

         // linear search on the item's side
         ST_FIND_RD: begin
            if (j_ff == cnt_s) begin
               state_in = ST_EMIT;
               ret_in   = ST_FINISH;
               case (mode_ff)
                  lobm_pkg::MODE_CANCEL:
                     rep_in = rep_plain(lobm_pkg::KIND_CXL_REJ, oid_ff, orig_ff, side_ff,
                                        '0, '0);
                  lobm_pkg::MODE_REPLACE:
                     rep_in = rep_plain(lobm_pkg::KIND_REPL_REJ, oid_ff, orig_ff, side_ff,
                                        '0, '0);
                  default:
                     rep_in = rep_plain(lobm_pkg::KIND_UNKNOWN, oid_ff, '0, side_ff, '0, '0);
               endcase
            end else begin
               mem_re    = 1'b1;
               mem_raddr = lobm_pkg::slot(side_ff, j_ff);
               state_in  = ST_FIND_CMP;
            end
         end

         ST_FIND_CMP: begin
            if (rd_data_ff.id == key) begin
               state_in   = ST_EMIT;
               rm_side_in = side_ff;
               case (mode_ff)
                  lobm_pkg::MODE_CANCEL: begin
                     rep_in    = rep_entry(lobm_pkg::KIND_CANCELED, rd_data_ff, oid_ff,
                                           orig_ff, side_ff, exec_ff);
                     exec_in   = exec_ff + 32'd1;
                     ret_in    = ST_RM_RD;
                     rm_ret_in = ST_FINISH;
                  end
                  lobm_pkg::MODE_REPLACE: begin
                     rep_in    = rep_entry(lobm_pkg::KIND_PEND_REPL, rd_data_ff, oid_ff,
                                           orig_ff, side_ff, exec_ff);
                     exec_in   = exec_ff + 32'd1;
                     ret_in    = ST_RM_RD;
                     rm_ret_in = ST_REPL;
                  end
                  default: begin
                     rep_in = rep_entry(lobm_pkg::KIND_STATUS, rd_data_ff, oid_ff, '0,
                                        side_ff, '0);
                     ret_in = ST_FINISH;
                  end
               endcase
            end else begin
               j_in     = j_inc;
               state_in = ST_FIND_RD;
            end
         end

         // close the gap at j by moving later entries up one
         ST_RM_RD: begin
            if (j_inc < rm_cnt) begin
               mem_re    = 1'b1;
               mem_raddr = lobm_pkg::slot(rm_side_ff, j_inc);
               state_in  = ST_RM_WR;
            end else begin
               if (rm_side_ff) begin
                  ask_cnt_in = ask_cnt_ff - lobm_pkg::CNT_W'(1);
               end else begin
                  bid_cnt_in = bid_cnt_ff - lobm_pkg::CNT_W'(1);
               end
               state_in = rm_ret_ff;
            end
         end

         ST_RM_WR: begin
            mem_we    = 1'b1;
            mem_waddr = lobm_pkg::slot(rm_side_ff, j_ff);
            mem_wdata = rd_data_ff;
            j_in      = j_inc;
            state_in  = ST_RM_RD;
         end

         ST_REPL: begin
            rep_in   = rep_plain(lobm_pkg::KIND_REPLACED, oid_ff, orig_ff, side_ff, qty_ff,
                                 exec_ff);
            exec_in  = exec_ff + 32'd1;
            ret_in   = ST_ADD;
            state_in = ST_EMIT;
         end

         ST_ADD: begin
            if (qty_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               j_in     = cnt_s;
               state_in = ST_INS_RD;
            end
         end

         // insertion from the tail: worse-priced entries shift down one
         ST_INS_RD: begin
            if (j_ff == '0) begin
               state_in = ST_INS_PUT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = lobm_pkg::slot(side_ff, j_dec);
               state_in  = ST_INS_CHK;
            end
         end

         ST_INS_CHK: begin
            if (move) begin
               mem_we    = 1'b1;
               mem_waddr = lobm_pkg::slot(side_ff, j_ff);
               mem_wdata = rd_data_ff;
               j_in      = j_dec;
               state_in  = ST_INS_RD;
            end else begin
               state_in = ST_INS_PUT;
            end
         end

         ST_INS_PUT: begin
            mem_we               = 1'b1;
            mem_waddr            = lobm_pkg::slot(side_ff, j_ff);
            mem_wdata            = '0;
            mem_wdata.id         = oid_ff;
            mem_wdata.price      = px_ff;
            mem_wdata.order_qty  = qty_ff;
            mem_wdata.leaves_qty = qty_ff;
            if (side_ff) begin
               ask_cnt_in = ask_cnt_ff + lobm_pkg::CNT_W'(1);
            end else begin
               bid_cnt_in = bid_cnt_ff + lobm_pkg::CNT_W'(1);
            end
            state_in = auto_match ? ST_MT_TOP : ST_FINISH;
         end

         // matching loop on the two best entries
         ST_MT_TOP: begin
            if (bid_cnt_ff == '0 || ask_cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = lobm_pkg::slot(1'b0, '0);
               state_in  = ST_MT_RDA;
            end
         end

         ST_MT_RDA: begin
            mem_re    = 1'b1;
            mem_raddr = lobm_pkg::slot(1'b1, '0);
            ent_b_in  = rd_data_ff;
            state_in  = ST_MT_CHK;
         end

         ST_MT_CHK: begin
            ent_a_in = rd_data_ff;
            q_in     = q_min;
            if (ent_b_ff.price < rd_data_ff.price || q_min == '0) begin
               state_in = ST_FINISH;
            end else begin
               avg_start = 1'b1;
               avg_op    = '{avg: rd_data_ff.avg_price, cum: rd_data_ff.cum_qty,
                             px: rd_data_ff.price, q: q_min};
               state_in  = ST_AVG_A;
            end
         end

         ST_AVG_A: begin
            if (avg_done) begin
               ent_a_in.avg_price  = avg_res;
               ent_a_in.leaves_qty = ent_a_ff.leaves_qty - q_ff;
               ent_a_in.cum_qty    = ent_a_ff.cum_qty + q_ff;
               ent_a_in.last_qty   = q_ff;
               ent_a_in.last_price = ent_a_ff.price;
               avg_start           = 1'b1;
               state_in            = ST_AVG_B;
            end
         end

         ST_AVG_B: begin
            if (avg_done) begin
               ent_b_in.avg_price  = avg_res;
               ent_b_in.leaves_qty = ent_b_ff.leaves_qty - q_ff;
               ent_b_in.cum_qty    = ent_b_ff.cum_qty + q_ff;
               ent_b_in.last_qty   = q_ff;
               ent_b_in.last_price = ent_a_ff.price;
               state_in            = ST_MT_WRA;
            end
         end

         ST_MT_WRA: begin
            mem_we    = 1'b1;
            mem_waddr = lobm_pkg::slot(1'b1, '0);
            mem_wdata = ent_a_ff;
            rep_in    = rep_entry((ent_a_ff.leaves_qty != '0) ? lobm_pkg::KIND_PARTIAL :
                                  lobm_pkg::KIND_FILLED, ent_a_ff, ent_a_ff.id, '0, 1'b1,
                                  exec_ff);
            exec_in   = exec_ff + 32'd1;
            ret_in    = ST_MT_WRB;
            state_in  = ST_EMIT;
         end

         ST_MT_WRB: begin
            mem_we    = 1'b1;
            mem_waddr = lobm_pkg::slot(1'b0, '0);
            mem_wdata = ent_b_ff;
            rep_in    = rep_entry((ent_b_ff.leaves_qty != '0) ? lobm_pkg::KIND_PARTIAL :
                                  lobm_pkg::KIND_FILLED, ent_b_ff, ent_b_ff.id, '0, 1'b0,
                                  exec_ff);
            exec_in   = exec_ff + 32'd1;
            rm_a_in   = (ent_a_ff.leaves_qty == '0);
            rm_b_in   = (ent_b_ff.leaves_qty == '0);
            ret_in    = ST_MT_POST;
            state_in  = ST_EMIT;
         end

         // drop filled heads, ask first
         ST_MT_POST: begin
            j_in      = '0;
            rm_ret_in = ST_MT_POST;
            if (rm_a_ff) begin
               rm_a_in    = 1'b0;
               rm_side_in = 1'b1;
               state_in   = ST_RM_RD;
            end else if (rm_b_ff) begin
               rm_b_in    = 1'b0;
               rm_side_in = 1'b0;
               state_in   = ST_RM_RD;
            end else begin
               state_in = ST_MT_TOP;
            end
         end

         ST_EMIT: begin
            oq_cmd.emit = oq_ok;
            if (oq_ok) begin
               state_in = ret_ff;
            end
         end

         ST_FINISH: begin
            oq_cmd.finish = oq_ok;
            if (oq_ok) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bid_cnt_ff <= '0;
         ask_cnt_ff <= '0;
         exec_ff    <= '0;
         rm_a_ff    <= 1'b0;
         rm_b_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bid_cnt_ff <= bid_cnt_in;
         ask_cnt_ff <= ask_cnt_in;
         exec_ff    <= exec_in;
         rm_a_ff    <= rm_a_in;
         rm_b_ff    <= rm_b_in;
      end
      ret_ff     <= ret_in;
      rm_ret_ff  <= rm_ret_in;
      mode_ff    <= mode_in;
      oid_ff     <= oid_in;
      orig_ff    <= orig_in;
      side_ff    <= side_in;
      px_ff      <= px_in;
      qty_ff     <= qty_in;
      j_ff       <= j_in;
      rm_side_ff <= rm_side_in;
      q_ff       <= q_in;
      ent_a_ff   <= ent_a_in;
      ent_b_ff   <= ent_b_in;
      rep_ff     <= rep_in;
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

`ifndef SYNTHESIS
   a_bid_bound: assert property (@(posedge clock) disable iff (reset)
      bid_cnt_ff <= lobm_pkg::CNT_W'(lobm_pkg::SIDE_DEPTH))
      else $error("bid count over depth");
   a_ask_bound: assert property (@(posedge clock) disable iff (reset)
      ask_cnt_ff <= lobm_pkg::CNT_W'(lobm_pkg::SIDE_DEPTH))
      else $error("ask count over depth");
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re && mem_waddr == mem_raddr))
      else $error("read and write of one slot in one cycle");
   a_exec_on_report: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && exec_ff != $past(exec_ff)) |-> state_ff == ST_EMIT)
      else $error("exec counter moved without a report");
   a_match_cross: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AVG_A |-> ent_b_ff.price >= ent_a_ff.price)
      else $error("trade without crossed book");
`endif

endmodule

// ----- hw/rtl/limit_order_book_matcher.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Word
// req_chan  in   valid/ready    mode, order_id, orig_order_id, side, price, quantity
// rsp_chan  out  valid/ready    one report; last_in_run marks the end of an item
// csr       in   csr_wr_en      csr_wr_data = auto_match
//
// One item at a time; req_chan is ready only while the sequencer is idle.
// Searches, shifts and close-ups step through the table one entry at a time;
// each trade runs two average updates in the shared average unit, each of 4
// multiply steps, 73 division steps and a done strobe.
// Reset clears both side counts, the execution counter and sets auto_match;
// the entry memory is not cleared, slots past a side's count are never read.
// The newest report waits in a holding word; a stalled rsp_chan stalls the
// sequencer only when that word and the output word are both full.
module limit_order_book_matcher (
   input  logic        clock,
   input  logic        reset,
   lobm_req_if.sink    req_chan,
   lobm_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                  auto_match_ff, auto_match_in;
   lobm_pkg::oq_cmd_type  oq_cmd;
   lobm_pkg::oq_stat_type oq_stat;

   // matching control register
   assign auto_match_in = csr_wr_en ? csr_wr_data : auto_match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_match_ff <= 1'b1;
      end else begin
         auto_match_ff <= auto_match_in;
      end
   end

   lobm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .auto_match (auto_match_ff),
      .oq_stat    (oq_stat),
      .oq_cmd     (oq_cmd)
   );

   lobm_out_queue u_out_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (oq_cmd),
      .stat  (oq_stat),
      .rsp   (rsp_chan)
   );

endmodule

// ----- tb/book_checker.sv -----
`timescale 1ns / 1ps

module book_checker (
   input  logic clock,
   input  logic reset,
   lobm_req_if  req,
   lobm_rsp_if  rsp,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   output int   words_in,
   output int   words_out,
   output int   fills_seen,
   output int   open_reports,
   output int   failures
);
   import lobm_pkg::*;

   // side 0 bids (best first, descending), side 1 asks (ascending)
   entry_type        book [2][SIDE_DEPTH];
   int               depth_of [2];
   logic [ID_W-1:0]  exec_next;
   logic             auto_on;
   report_type       owed_reports [$];
   report_type       item_reports [$];

   initial begin
      words_in = 0;
      words_out = 0;
      fills_seen = 0;
      open_reports = 0;
      failures = 0;
   end

   function automatic logic [AVG_W-1:0] blend_avg(input logic [AVG_W-1:0] avg,
                                                  input logic [QTY_W-1:0] cum,
                                                  input logic [PX_W-1:0] px,
                                                  input logic [QTY_W-1:0] q);
      logic [127:0] num;
      logic [127:0] den;
      den = 128'(cum) + 128'(q);
      if (den == 0) return avg;
      num = ((128'(q) * 128'(px)) << FRAC_W) + 128'(avg) * 128'(cum);
      return AVG_W'(num / den);
   endfunction

   function automatic logic [ID_W-1:0] take_exec();
      logic [ID_W-1:0] v;
      v = exec_next;
      exec_next = exec_next + 1'b1;
      return v;
   endfunction

   task automatic put(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                      input logic [ID_W-1:0] orig, input logic side,
                      input logic [QTY_W-1:0] oq, input logic [QTY_W-1:0] lv,
                      input logic [QTY_W-1:0] cum, input logic [AVG_W-1:0] avg,
                      input logic [QTY_W-1:0] lq, input logic [PX_W-1:0] lp,
                      input logic [ID_W-1:0] ex);
      report_type r;
      r.report_kind = kind;
      r.report_order_id = id;
      r.report_orig_id = orig;
      r.report_side = side;
      r.order_qty = oq;
      r.leaves_qty = lv;
      r.cum_qty = cum;
      r.avg_price = avg;
      r.last_qty = lq;
      r.last_price = lp;
      r.exec_id = ex;
      r.last_in_run = 1'b0;
      item_reports.insert(item_reports.size(), r);
   endtask

   task automatic put_entry(input logic [KIND_W-1:0] kind, input entry_type e,
                            input logic [ID_W-1:0] id, input logic [ID_W-1:0] orig,
                            input logic side, input logic [ID_W-1:0] ex);
      put(kind, id, orig, side, e.order_qty, e.leaves_qty, e.cum_qty, e.avg_price,
          e.last_qty, e.last_price, ex);
   endtask

   function automatic int locate(input int s, input logic [ID_W-1:0] id);
      for (int i = 0; i < depth_of[s]; i++)
         if (book[s][i].id == id) return i;
      return -1;
   endfunction

   task automatic drop(input int s, input int i);
      for (int j = i; j < depth_of[s] - 1; j++) book[s][j] = book[s][j+1];
      if (depth_of[s] > 0) depth_of[s]--;
   endtask

   // insert keeping price-time priority
   task automatic rest(input int s, input logic [ID_W-1:0] id,
                       input logic [PX_W-1:0] px, input logic [QTY_W-1:0] q);
      entry_type e;
      int pos;
      pos = 0;
      while (pos < depth_of[s]) begin
         if (s == 1 ? (book[s][pos].price > px) : (book[s][pos].price < px)) break;
         pos++;
      end
      for (int j = depth_of[s]; j > pos; j--) book[s][j] = book[s][j-1];
      e = '0;
      e.id = id;
      e.price = px;
      e.order_qty = q;
      e.leaves_qty = q;
      book[s][pos] = e;
      depth_of[s]++;
   endtask

   task automatic fill_top(input int s, input logic [PX_W-1:0] px, input logic [QTY_W-1:0] q);
      entry_type e;
      e = book[s][0];
      e.avg_price = blend_avg(e.avg_price, e.cum_qty, px, q);
      e.leaves_qty = e.leaves_qty - q;
      e.cum_qty = e.cum_qty + q;
      e.last_qty = q;
      e.last_price = px;
      book[s][0] = e;
   endtask

   // trade while the book is crossed, ask report first
   task automatic cross_book();
      logic [PX_W-1:0]  px;
      logic [QTY_W-1:0] q;
      while (depth_of[0] > 0 && depth_of[1] > 0) begin
         if (book[0][0].price < book[1][0].price) break;
         px = book[1][0].price;
         q = (book[0][0].leaves_qty > book[1][0].leaves_qty) ?
             book[1][0].leaves_qty : book[0][0].leaves_qty;
         if (q == 0) break;
         fill_top(1, px, q);
         fill_top(0, px, q);
         put_entry(book[1][0].leaves_qty != 0 ? KIND_PARTIAL : KIND_FILLED, book[1][0],
                   book[1][0].id, '0, 1'b1, take_exec());
         put_entry(book[0][0].leaves_qty != 0 ? KIND_PARTIAL : KIND_FILLED, book[0][0],
                   book[0][0].id, '0, 1'b0, take_exec());
         if (book[1][0].leaves_qty == 0) drop(1, 0);
         if (book[0][0].leaves_qty == 0) drop(0, 0);
      end
   endtask

   task automatic add_order(input int s, input logic [ID_W-1:0] id,
                            input logic [PX_W-1:0] px, input logic [QTY_W-1:0] q);
      if (q == 0 || depth_of[s] >= SIDE_DEPTH) return;
      rest(s, id, px, q);
      if (auto_on) cross_book();
   endtask

   task automatic predict_reports(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                                  input logic [ID_W-1:0] orig, input logic side,
                                  input logic [PX_W-1:0] px, input logic [QTY_W-1:0] q);
      int s;
      int i;
      s = side;
      item_reports.delete();
      case (mode)
         MODE_NEW: begin
            if (depth_of[s] >= SIDE_DEPTH) begin
               put(KIND_BOOK_FULL, id, '0, side, '0, '0, '0, '0, '0, '0, '0);
            end else begin
               put(KIND_NEW, id, '0, side, q, q, '0, '0, '0, '0, take_exec());
               add_order(s, id, px, q);
            end
         end
         MODE_CANCEL: begin
            i = locate(s, orig);
            if (i < 0) begin
               put(KIND_CXL_REJ, id, orig, side, '0, '0, '0, '0, '0, '0, '0);
            end else begin
               put_entry(KIND_CANCELED, book[s][i], id, orig, side, take_exec());
               drop(s, i);
            end
         end
         MODE_REPLACE: begin
            i = locate(s, orig);
            if (i < 0) begin
               put(KIND_REPL_REJ, id, orig, side, '0, '0, '0, '0, '0, '0, '0);
            end else begin
               put_entry(KIND_PEND_REPL, book[s][i], id, orig, side, take_exec());
               drop(s, i);
               put(KIND_REPLACED, id, orig, side, q, q, '0, '0, '0, '0, take_exec());
               add_order(s, id, px, q);
            end
         end
         MODE_STATUS: begin
            i = locate(s, id);
            if (i < 0) put(KIND_UNKNOWN, id, '0, side, '0, '0, '0, '0, '0, '0, '0);
            else put_entry(KIND_STATUS, book[s][i], id, '0, side, '0);
         end
         MODE_MATCH: cross_book();
         default: ;
      endcase
      if (item_reports.size() > 0) item_reports[item_reports.size()-1].last_in_run = 1'b1;
      foreach (item_reports[k]) owed_reports.insert(owed_reports.size(), item_reports[k]);
   endtask

   task automatic note(input string what, input logic [63:0] got, input logic [63:0] want);
      failures++;
      $display("report %0d: %s got %0h expected %0h", words_out, what, got, want);
   endtask

   task automatic compare(input report_type got, input report_type want);
      if (got.report_kind != want.report_kind)
         note("report_kind", got.report_kind, want.report_kind);
      if (got.report_order_id != want.report_order_id)
         note("report_order_id", got.report_order_id, want.report_order_id);
      if (got.report_orig_id != want.report_orig_id)
         note("report_orig_id", got.report_orig_id, want.report_orig_id);
      if (got.report_side != want.report_side)
         note("report_side", got.report_side, want.report_side);
      if (got.order_qty != want.order_qty) note("order_qty", got.order_qty, want.order_qty);
      if (got.leaves_qty != want.leaves_qty)
         note("leaves_qty", got.leaves_qty, want.leaves_qty);
      if (got.cum_qty != want.cum_qty) note("cum_qty", got.cum_qty, want.cum_qty);
      if (got.avg_price != want.avg_price) note("avg_price", got.avg_price, want.avg_price);
      if (got.last_qty != want.last_qty) note("last_qty", got.last_qty, want.last_qty);
      if (got.last_price != want.last_price)
         note("last_price", got.last_price, want.last_price);
      if (got.exec_id != want.exec_id) note("exec_id", got.exec_id, want.exec_id);
      if (got.last_in_run != want.last_in_run)
         note("last_in_run", got.last_in_run, want.last_in_run);
   endtask

   // watch both channels and the register port at each rising edge
   always @(posedge clock) begin
      report_type got;
      if (reset) begin
         depth_of[0] = 0;
         depth_of[1] = 0;
         exec_next = '0;
         auto_on = 1'b1;
         owed_reports.delete();
      end else begin
         if (csr_wr_en) auto_on = csr_wr_data;
         if (req.valid && req.ready) begin
            words_in++;
            predict_reports(req.mode, req.order_id, req.orig_order_id, req.side,
                            req.price, req.quantity);
         end
         if (rsp.valid && rsp.ready) begin
            words_out++;
            got.report_kind = rsp.report_kind;
            got.report_order_id = rsp.report_order_id;
            got.report_orig_id = rsp.report_orig_id;
            got.report_side = rsp.report_side;
            got.order_qty = rsp.order_qty;
            got.leaves_qty = rsp.leaves_qty;
            got.cum_qty = rsp.cum_qty;
            got.avg_price = rsp.avg_price;
            got.last_qty = rsp.last_qty;
            got.last_price = rsp.last_price;
            got.exec_id = rsp.exec_id;
            got.last_in_run = rsp.last_in_run;
            if (got.report_kind == KIND_PARTIAL || got.report_kind == KIND_FILLED)
               fills_seen++;
            if (owed_reports.size() == 0) note("unexpected report, kind", got.report_kind, 0);
            else compare(got, owed_reports.pop_front());
         end
      end
      open_reports = owed_reports.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import lobm_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam int STALL_LIMIT = 40000;
   localparam int SETTLE_CYCLES = 400;
   localparam int LONG_HOLD = 300;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   logic quiet;
   logic hold_rsp;
   int   words_in, words_out, fills_seen, open_reports, failures;
   int   idle_cycles, last_moves;

   lobm_req_if req_chan ();
   lobm_rsp_if rsp_chan ();

   limit_order_book_matcher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   book_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .words_in     (words_in),
      .words_out    (words_out),
      .fills_seen   (fills_seen),
      .open_reports (open_reports),
      .failures     (failures)
   );

   always #5 clock = ~clock;

   // report receiver: random stalls, one long hold on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no word moving on either channel
   always @(negedge clock) begin
      if (words_in + words_out != last_moves) begin
         last_moves = words_in + words_out;
         idle_cycles = 0;
      end else if (++idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // offer one word, return at the falling edge after it is taken
   task automatic offer(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                        input logic [ID_W-1:0] orig, input logic side,
                        input logic [PX_W-1:0] px, input logic [QTY_W-1:0] q);
      int target;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.order_id <= id;
      req_chan.orig_order_id <= orig;
      req_chan.side <= side;
      req_chan.price <= px;
      req_chan.quantity <= q;
      target = words_in + 1;
      do @(negedge clock); while (words_in < target);
   endtask

   // wait until every report is back and the engine has settled
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (open_reports != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_auto(input logic v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [MODE_W-1:0] MODE_MODE_SPARE_PICK();
      return MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
   endfunction

   // mostly a small id pool and a narrow price band so orders meet
   task automatic random_word();
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   id, orig;
      logic [PX_W-1:0]   px;
      logic [QTY_W-1:0]  q;
      int                r;
      r = $urandom_range(0, 99);
      if (r < 50) mode = MODE_NEW;
      else if (r < 62) mode = MODE_CANCEL;
      else if (r < 74) mode = MODE_REPLACE;
      else if (r < 86) mode = MODE_STATUS;
      else if (r < 96) mode = MODE_MATCH;
      else mode = MODE_MODE_SPARE_PICK();
      id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 12);
      orig = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 12);
      px = ($urandom_range(0, 14) == 0) ? $urandom : $urandom_range(1000, 1020);
      r = $urandom_range(0, 29);
      if (r == 0) q = '0;
      else if (r == 1) q = '1;
      else if (r == 2) q = QTY_W'($urandom);
      else q = QTY_W'($urandom_range(1, 60));
      offer(mode, id, orig, 1'($urandom_range(0, 1)), px, q);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      idle_cycles = 0;
      last_moves = 0;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_NEW;
      req_chan.order_id = '0;
      req_chan.orig_order_id = '0;
      req_chan.side = 1'b0;
      req_chan.price = '0;
      req_chan.quantity = '0;
      rsp_chan.ready = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_auto(1'b1);

      // directed: rejects, spare modes, extremes, zero quantity
      offer(MODE_STATUS, 32'd0, 32'd0, 1'b0, 32'd0, 24'd1);
      offer(MODE_CANCEL, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0, 24'd1);
      offer(MODE_REPLACE, 32'd2, 32'd77, 1'b0, 32'd5, 24'd5);
      offer(MODE_SPARE_LO, 32'd3, 32'd3, 1'b0, 32'd5, 24'd5);
      offer(MODE_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '1, '1);
      offer(MODE_NEW, 32'd4, 32'd0, 1'b0, 32'd500, 24'd0);
      offer(MODE_NEW, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF);
      offer(MODE_NEW, 32'd5, 32'd0, 1'b1, 32'd0, 24'd1);
      offer(MODE_NEW, 32'd6, 32'd0, 1'b1, 32'hFFFF_FFFE, 24'd3);
      offer(MODE_STATUS, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0, 24'd1);
      offer(MODE_REPLACE, 32'd7, 32'hFFFF_FFFF, 1'b0, 32'd40, 24'd9);
      offer(MODE_REPLACE, 32'd8, 32'd7, 1'b0, 32'd40, 24'd0);
      offer(MODE_MATCH, 32'd0, 32'd0, 1'b0, 32'd0, 24'd1);
      // fill the bid side past its depth, duplicate id included
      for (int i = 0; i <= SIDE_DEPTH; i++)
         offer(MODE_NEW, 32'd20 + (i % 7), 32'd0, 1'b0, 32'd10 + i, 24'(i + 1));
      offer(MODE_CANCEL, 32'd30, 32'd20, 1'b0, 32'd0, 24'd1);
      // one sell sweeps the whole bid side
      offer(MODE_NEW, 32'd31, 32'd0, 1'b1, 32'd5, 24'hFF_FFFF);
      offer(MODE_STATUS, 32'd31, 32'd0, 1'b1, 32'd0, 24'd1);
      offer(MODE_CANCEL, 32'd32, 32'd31, 1'b1, 32'd0, 24'd1);

      // resting without auto matching, crossed only by match commands;
      // this pause lets every report come back before the register moves
      settle();
      write_auto(1'b0);
      repeat (50) random_word();

      settle();
      write_auto(1'b1);
      repeat (25) random_word();
      hold_rsp = 1'b1;
      repeat (25) random_word();
      quiet = 1'b1;
      repeat (25) random_word();

      settle();
      $display("%0d items in, %0d reports checked, %0d of them fills", words_in, words_out,
               fills_seen);
      $display("auto matching on and off, full sides, replaces, cancels, status covered");
      if (open_reports != 0) $display("%0d reports never came", open_reports);
      if (failures == 0 && open_reports == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
